// ----- hw/rtl/grpw_pkg.sv -----
// shared types and constants of the glyph row pixel writer
package grpw_pkg;

   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 16;

   localparam logic [31:0] TRANSPARENT_COLOR = 32'hFFFF_FFFF;
   localparam logic [7:0]  LEFT_PIXEL_MASK   = 8'h80;

   localparam int CSR_INDEX_WIDTH = 3;

   // register reset values
   localparam logic        ENABLE_RESET        = 1'b0;
   localparam logic [31:0] DRAW_BASE_RESET     = 32'd0;
   localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd768;
   localparam logic [14:0] LINE_PITCH_RESET    = 15'd4096;
   localparam logic [1:0]  PIXEL_FORMAT_RESET  = 2'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_DRAW_BASE     = 3'd1,
      CSR_SCREEN_WIDTH  = 3'd2,
      CSR_SCREEN_HEIGHT = 3'd3,
      CSR_LINE_PITCH    = 3'd4,
      CSR_PIXEL_FORMAT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_16BPP = 2'd0,
      FMT_24BPP = 2'd1,
      FMT_32BPP = 2'd2
   } pixel_format_type;

   typedef struct packed {
      logic signed [15:0] glyph_x;
      logic signed [15:0] glyph_y;
      logic [3:0]         row_index;
      logic [7:0]         row_bits;
      logic [31:0]        fg_color;
      logic [31:0]        bg_color;
   } req_type;

   typedef struct packed {
      logic [31:0] write_address;
      logic [31:0] write_data;
      logic [2:0]  byte_count;
      logic        last;
   } rsp_type;

endpackage

// ----- hw/rtl/glyph_row_pixel_writer_top.sv -----
// glyph row pixel writer: one glyph row in, clipped framebuffer pixel writes out
//
// Each request carries one 8-pixel row of a monochrome glyph. Set bits write the
// foreground color, clear bits the background color unless the background is
// all ones (transparent). Pixels outside screen_width x screen_height are
// clipped. Every drawn pixel leaves as one response, left to right, with the
// byte address draw_base + y*line_pitch + x*bytes (wrapping at 2^32), the color
// masked to 2, 3 or 4 bytes, the byte count and a last flag on the row's final
// write. A request passes three register stages (clip, multiply, address
// add) and then a pixel serializer and the response register before its
// first write appears. The serializer and the single response port set the
// pace: a row holds the serializer until all of its drawn pixels are sent,
// rows that draw nothing take no serializer time, and later rows wait in the
// register stages meanwhile, so requests stall only when those are full or
// the response side holds off. Configuration writes are always accepted and
// must only be made while no row is in flight.
module glyph_row_pixel_writer_top (
   input  logic              clock,
   input  logic              reset,
   // row requests
   input  logic              req_valid,
   output logic              req_ready,
   input  grpw_pkg::req_type req_data,
   // pixel write responses
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grpw_pkg::rsp_type rsp_data,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [grpw_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                            csr_wdata
);

   // ---------------------------------------------------------------
   // stage payloads
   // ---------------------------------------------------------------
   // after clipping: row on screen, per-column draw mask (bit c = column c)
   typedef struct packed {
      logic [12:0] py;
      logic [15:0] gx;
      logic [7:0]  mask;
      logic [7:0]  row_bits;
      logic [31:0] fg;
      logic [31:0] bg;
   } s1_type;

   // after the line multiply and the column offset
   typedef struct packed {
      logic [27:0] line_offset;
      logic [31:0] col_offset;
      logic [7:0]  mask;
      logic [7:0]  row_bits;
      logic [31:0] fg;
      logic [31:0] bg;
      logic [2:0]  bytes;
   } s2_type;

   // start address of column 0, ready for the serializer
   typedef struct packed {
      logic [31:0] start;
      logic [7:0]  mask;
      logic [7:0]  row_bits;
      logic [31:0] fg;
      logic [31:0] bg;
      logic [2:0]  bytes;
   } s3_type;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic        enable_ff,        enable_in;
   logic [31:0] draw_base_ff,     draw_base_in;
   logic [12:0] screen_width_ff,  screen_width_in;
   logic [12:0] screen_height_ff, screen_height_in;
   logic [14:0] line_pitch_ff,    line_pitch_in;
   logic [1:0]  pixel_format_ff,  pixel_format_in;

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in        = enable_ff;
      draw_base_in     = draw_base_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      line_pitch_in    = line_pitch_ff;
      pixel_format_in  = pixel_format_ff;
      if (csr_valid) begin
         // indexes past the register list are dropped
         case (grpw_pkg::csr_index_type'(csr_index))
            grpw_pkg::CSR_ENABLE:        enable_in        = csr_wdata[0];
            grpw_pkg::CSR_DRAW_BASE:     draw_base_in     = csr_wdata;
            grpw_pkg::CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata[12:0];
            grpw_pkg::CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata[12:0];
            grpw_pkg::CSR_LINE_PITCH:    line_pitch_in    = csr_wdata[14:0];
            grpw_pkg::CSR_PIXEL_FORMAT:  pixel_format_in  = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= grpw_pkg::ENABLE_RESET;
         draw_base_ff     <= grpw_pkg::DRAW_BASE_RESET;
         screen_width_ff  <= grpw_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= grpw_pkg::SCREEN_HEIGHT_RESET;
         line_pitch_ff    <= grpw_pkg::LINE_PITCH_RESET;
         pixel_format_ff  <= grpw_pkg::PIXEL_FORMAT_RESET;
      end else begin
         enable_ff        <= enable_in;
         draw_base_ff     <= draw_base_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         line_pitch_ff    <= line_pitch_in;
         pixel_format_ff  <= pixel_format_in;
      end
   end

   // pixel format decode, to be kept static by the user while rows are in flight (unenforced)
   logic        fmt_ok;
   logic [2:0]  fmt_bytes;
   logic [31:0] fmt_dmask;

   always_comb begin
      case (grpw_pkg::pixel_format_type'(pixel_format_ff))
         grpw_pkg::FMT_16BPP: begin
            fmt_ok    = 1'b1;
            fmt_bytes = 3'd2;
            fmt_dmask = 32'h0000_FFFF;
         end
         grpw_pkg::FMT_24BPP: begin
            fmt_ok    = 1'b1;
            fmt_bytes = 3'd3;
            fmt_dmask = 32'h00FF_FFFF;
         end
         grpw_pkg::FMT_32BPP: begin
            fmt_ok    = 1'b1;
            fmt_bytes = 3'd4;
            fmt_dmask = 32'hFFFF_FFFF;
         end
         default: begin
            // unused format draws nothing
            fmt_ok    = 1'b0;
            fmt_bytes = 3'd4;
            fmt_dmask = 32'hFFFF_FFFF;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // flow control: each stage moves when the next one has room
   // ---------------------------------------------------------------
   logic   s1_valid_ff, s1_valid_in;
   logic   s2_valid_ff, s2_valid_in;
   logic   s3_valid_ff, s3_valid_in;
   logic   ser_valid_ff, ser_valid_in;
   logic   rsp_valid_ff, rsp_valid_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type ser_ff, ser_in;
   s3_type s3_ff, s3_in;
   grpw_pkg::rsp_type rsp_ff, rsp_in;

   logic       out_free;
   logic       ser_emit;
   logic       ser_last;
   logic       ser_take;
   logic       s1_ready, s2_ready, s3_ready;
   logic [2:0] ser_col;
   logic [7:0] ser_rest;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ser_emit = ser_valid_ff && out_free;
   assign ser_take = !ser_valid_ff || (ser_emit && ser_last);
   assign s3_ready = !s3_valid_ff || ser_take;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // ---------------------------------------------------------------
   // stage 1: row and column clipping, draw mask
   // ---------------------------------------------------------------
   logic [16:0] py_wide;
   logic        y_ok;
   logic        row_ok;
   logic [16:0] px_wide;
   logic [7:0]  draw_mask;

   always_comb begin
      // sign-extended sum never overflows 17 bits
      py_wide = {req_data.glyph_y[15], req_data.glyph_y} + {13'd0, req_data.row_index};
      y_ok    = !py_wide[16] && (py_wide[15:0] < {3'd0, screen_height_ff});
      row_ok  = int'(req_data.row_index) < grpw_pkg::GLYPH_HEIGHT;
      px_wide = '0;
      for (int col = 0; col < grpw_pkg::GLYPH_WIDTH; col++) begin
         px_wide = {req_data.glyph_x[15], req_data.glyph_x} + 17'(col);
         draw_mask[col] = !px_wide[16]
                        && (px_wide[15:0] < {3'd0, screen_width_ff})
                        && ((|(req_data.row_bits & (grpw_pkg::LEFT_PIXEL_MASK >> col)))
                            || (req_data.bg_color != grpw_pkg::TRANSPARENT_COLOR));
      end

      s1_in.py       = py_wide[12:0];
      s1_in.gx       = req_data.glyph_x;
      s1_in.mask     = (enable_ff && row_ok && fmt_ok && y_ok) ? draw_mask : 8'd0;
      s1_in.row_bits = req_data.row_bits;
      s1_in.fg       = req_data.fg_color;
      s1_in.bg       = req_data.bg_color;
      s1_valid_in    = s1_ready ? req_valid : s1_valid_ff;
   end

   // ---------------------------------------------------------------
   // stage 2: y * line_pitch, glyph_x * bytes, color masking
   // ---------------------------------------------------------------
   logic [31:0] gx_ext;

   always_comb begin
      gx_ext = {{16{s1_ff.gx[15]}}, s1_ff.gx};
      case (grpw_pkg::pixel_format_type'(pixel_format_ff))
         grpw_pkg::FMT_16BPP: s2_in.col_offset = gx_ext << 1;
         grpw_pkg::FMT_24BPP: s2_in.col_offset = gx_ext + (gx_ext << 1);
         grpw_pkg::FMT_32BPP: s2_in.col_offset = gx_ext << 2;
         default:             s2_in.col_offset = 32'd0;
      endcase
      // 13 x 15 bit product
      s2_in.line_offset = {15'd0, s1_ff.py} * {13'd0, line_pitch_ff};
      s2_in.mask        = s1_ff.mask;
      s2_in.row_bits    = s1_ff.row_bits;
      s2_in.fg          = s1_ff.fg & fmt_dmask;
      s2_in.bg          = s1_ff.bg & fmt_dmask;
      s2_in.bytes       = fmt_bytes;
      s2_valid_in       = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   // ---------------------------------------------------------------
   // stage 3: start address; rows with nothing to draw vanish here
   // ---------------------------------------------------------------
   always_comb begin
      s3_in.start    = draw_base_ff + {4'd0, s2_ff.line_offset} + s2_ff.col_offset;
      s3_in.mask     = s2_ff.mask;
      s3_in.row_bits = s2_ff.row_bits;
      s3_in.fg       = s2_ff.fg;
      s3_in.bg       = s2_ff.bg;
      s3_in.bytes    = s2_ff.bytes;
      s3_valid_in    = s3_ready ? (s2_valid_ff && (s2_ff.mask != 8'd0)) : s3_valid_ff;
   end

   // ---------------------------------------------------------------
   // serializer: one drawn pixel per cycle while the response register has room, leftmost first
   // ---------------------------------------------------------------
   logic [7:0] ser_pick;
   logic [5:0] ser_step;

   always_comb begin
      // lowest set mask bit is the leftmost remaining column
      ser_pick = ser_ff.mask & (~ser_ff.mask + 8'd1);
      ser_rest = ser_ff.mask & ~ser_pick;
      ser_last = (ser_rest == 8'd0);
      ser_col  = 3'd0;
      for (int col = grpw_pkg::GLYPH_WIDTH - 1; col >= 0; col--) begin
         if (ser_pick[col]) begin
            ser_col = 3'(col);
         end
      end
      ser_step = {3'd0, ser_col} * {3'd0, ser_ff.bytes};

      ser_in       = ser_ff;
      ser_valid_in = ser_valid_ff;
      if (ser_take) begin
         ser_valid_in = s3_valid_ff;
         ser_in       = s3_ff;
      end else if (ser_emit) begin
         ser_in.mask = ser_rest;
      end
   end

   // ---------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ser_emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.write_address = ser_ff.start + {26'd0, ser_step};
         // row bit 7 is column 0
         rsp_in.write_data    = ser_ff.row_bits[~ser_col] ? ser_ff.fg : ser_ff.bg;
         rsp_in.byte_count    = ser_ff.bytes;
         rsp_in.last          = ser_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         ser_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         ser_valid_ff <= ser_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
      ser_ff <= ser_in;
      rsp_ff <= rsp_in;
   end

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // a row held in the serializer always has a pixel left to send
   assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (ser_ff.mask != 8'd0))
      else $error("serializer holds a row with an empty draw mask");

   // each emitted pixel that is not the last removes exactly one mask bit
   assert property (@(posedge clock) disable iff (reset)
      (ser_emit && !ser_last) |=>
         (ser_valid_ff && ($countones(ser_ff.mask) == $countones($past(ser_ff.mask)) - 1)))
      else $error("serializer dropped or repeated a pixel");

   // a row taken while drawing is disabled carries an empty mask
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !enable_ff) |=> (s1_ff.mask == 8'd0))
      else $error("row accepted while disabled has pixels to draw");

   // byte count is always one of the three pixel sizes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.byte_count == 3'd2 || rsp_ff.byte_count == 3'd3
                        || rsp_ff.byte_count == 3'd4))
      else $error("response byte count out of range");

endmodule

// ----- tb/tb_glyph_row_pixel_writer_top.sv -----
// self-checking testbench for the glyph row pixel writer: predicted writes vs. dut writes

class pixel_write_scoreboard;
   logic        enable;
   logic [31:0] draw_base;
   logic [12:0] screen_width;
   logic [12:0] screen_height;
   logic [14:0] line_pitch;
   logic [1:0]  pixel_format;

   grpw_pkg::rsp_type pending_writes[$];
   int mismatches;
   int rows_noted;
   int writes_checked;
   int registers_written;

   function new();
      enable            = grpw_pkg::ENABLE_RESET;
      draw_base         = grpw_pkg::DRAW_BASE_RESET;
      screen_width      = grpw_pkg::SCREEN_WIDTH_RESET;
      screen_height     = grpw_pkg::SCREEN_HEIGHT_RESET;
      line_pitch        = grpw_pkg::LINE_PITCH_RESET;
      pixel_format      = grpw_pkg::PIXEL_FORMAT_RESET;
      mismatches        = 0;
      rows_noted        = 0;
      writes_checked    = 0;
      registers_written = 0;
   endfunction

   function void set_register(grpw_pkg::csr_index_type idx, logic [31:0] value);
      registers_written++;
      case (idx)
         grpw_pkg::CSR_ENABLE:        enable        = value[0];
         grpw_pkg::CSR_DRAW_BASE:     draw_base     = value;
         grpw_pkg::CSR_SCREEN_WIDTH:  screen_width  = value[12:0];
         grpw_pkg::CSR_SCREEN_HEIGHT: screen_height = value[12:0];
         grpw_pkg::CSR_LINE_PITCH:    line_pitch    = value[14:0];
         grpw_pkg::CSR_PIXEL_FORMAT:  pixel_format  = value[1:0];
         default: ;
      endcase
   endfunction

   // expand one accepted row into the pixel writes it must cause
   function void note_request(grpw_pkg::req_type r);
      grpw_pkg::rsp_type row_writes[$];
      grpw_pkg::rsp_type wr;
      longint            py;
      longint            px;
      logic [2:0]        bytes;
      logic [31:0]       keep_mask;
      logic [31:0]       color;
      longint unsigned   addr;
      rows_noted++;
      if (!enable || int'(r.row_index) >= grpw_pkg::GLYPH_HEIGHT)
         return;
      case (pixel_format)
         grpw_pkg::FMT_16BPP: begin
            bytes = 3'd2; keep_mask = 32'h0000_FFFF;
         end
         grpw_pkg::FMT_24BPP: begin
            bytes = 3'd3; keep_mask = 32'h00FF_FFFF;
         end
         grpw_pkg::FMT_32BPP: begin
            bytes = 3'd4; keep_mask = 32'hFFFF_FFFF;
         end
         default: return;
      endcase
      py = longint'($signed(r.glyph_y)) + longint'(r.row_index);
      if (py < 0 || py >= longint'(screen_height))
         return;
      for (int col = 0; col < grpw_pkg::GLYPH_WIDTH; col++) begin
         px = longint'($signed(r.glyph_x)) + col;
         if (px < 0 || px >= longint'(screen_width))
            continue;
         if ((r.row_bits & (grpw_pkg::LEFT_PIXEL_MASK >> col)) != 0)
            color = r.fg_color;
         else if (r.bg_color != grpw_pkg::TRANSPARENT_COLOR)
            color = r.bg_color;
         else
            continue;
         addr = longint'(draw_base) + py * longint'(line_pitch) + px * longint'(bytes);
         wr.write_address = addr[31:0];
         wr.write_data    = color & keep_mask;
         wr.byte_count    = bytes;
         wr.last          = 1'b0;
         row_writes.push_back(wr);
      end
      if (row_writes.size() > 0)
         row_writes[row_writes.size() - 1].last = 1'b1;
      foreach (row_writes[i])
         pending_writes.push_back(row_writes[i]);
   endfunction

   function void check_write(grpw_pkg::rsp_type got);
      grpw_pkg::rsp_type want;
      if (pending_writes.size() == 0) begin
         $error("unexpected pixel write: write_address %h write_data %h",
                got.write_address, got.write_data);
         mismatches++;
         return;
      end
      want = pending_writes.pop_front();
      writes_checked++;
      if (got.write_address !== want.write_address) begin
         $error("write_address: expected %h, actual %h", want.write_address, got.write_address);
         mismatches++;
      end
      if (got.write_data !== want.write_data) begin
         $error("write_data: expected %h, actual %h", want.write_data, got.write_data);
         mismatches++;
      end
      if (got.byte_count !== want.byte_count) begin
         $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
         mismatches++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %b, actual %b", want.last, got.last);
         mismatches++;
      end
   endfunction
endclass

module tb_glyph_row_pixel_writer_top;
   timeunit 1ns;
   timeprecision 1ps;

   // a row that draws nothing may still sit in the pipe when the last write is seen
   localparam int PIPE_SETTLE  = 12;
   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT  = 3000;
   // length of the deliberate response hold-off
   localparam int HOLD_CYCLES  = 400;
   // the one pixel format code the block does not use
   localparam logic [1:0] FMT_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   grpw_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   grpw_pkg::rsp_type rsp_data;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [grpw_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                          csr_wdata = '0;

   pixel_write_scoreboard sb;

   // idling knobs: sender gap odds live in the main process only,
   // receiver stall odds and hold-off requests are handed over by nonblocking writes
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int settings_applied = 0;

   glyph_row_pixel_writer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // response side: check every accepted write, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_write(rsp_data);
      if (hold_left > 0) begin
         // long hold-off in progress, counted here
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // hang detector: any accepted request, write or register write resets it
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   // register write; csr_valid stays high so back-to-back writes need no toggle
   task automatic write_register(grpw_pkg::csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, value);
   endtask

   // program all six registers; unused upper bits carry junk, which must be ignored
   task automatic apply_settings(logic en, logic [31:0] base, logic [12:0] width,
                                 logic [12:0] height, logic [14:0] pitch, logic [1:0] fmt);
      logic [31:0] junk;
      junk = $urandom();
      write_register(grpw_pkg::CSR_ENABLE,        {junk[31:1], en});
      write_register(grpw_pkg::CSR_DRAW_BASE,     base);
      write_register(grpw_pkg::CSR_SCREEN_WIDTH,  {junk[31:13], width});
      write_register(grpw_pkg::CSR_SCREEN_HEIGHT, {junk[18:0], height});
      write_register(grpw_pkg::CSR_LINE_PITCH,    {junk[31:15], pitch});
      write_register(grpw_pkg::CSR_PIXEL_FORMAT,  {junk[29:0], fmt});
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // offer one request; valid is only lowered when a gap is actually taken
   task automatic send_row(grpw_pkg::req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic send_glyph_row(int x, int y, int row, logic [7:0] bits,
                                 logic [31:0] fg, logic [31:0] bg);
      grpw_pkg::req_type r;
      r.glyph_x   = 16'(x);
      r.glyph_y   = 16'(y);
      r.row_index = 4'(row);
      r.row_bits  = bits;
      r.fg_color  = fg;
      r.bg_color  = bg;
      send_row(r);
   endtask

   // mostly rows that land on or just around the screen, some anywhere at all
   function automatic grpw_pkg::req_type random_row();
      grpw_pkg::req_type r;
      logic [31:0]       raw;
      int                py;
      r.row_index = 4'($urandom_range(15));
      if ($urandom_range(99) < 85) begin
         r.glyph_x = 16'(int'($urandom_range(int'(sb.screen_width) + 8)) - 8);
         py        = int'($urandom_range(int'(sb.screen_height) + 1)) - 1;
         r.glyph_y = 16'(py - int'(r.row_index));
      end else begin
         raw       = $urandom();
         r.glyph_x = raw[15:0];
         r.glyph_y = raw[31:16];
      end
      raw        = $urandom();
      r.row_bits = raw[7:0];
      r.fg_color = $urandom();
      r.bg_color = ($urandom_range(99) < 30) ? grpw_pkg::TRANSPARENT_COLOR : $urandom();
      return r;
   endfunction

   // stop offering, let every expected write arrive, then let the pipe settle
   task automatic drain_writes();
      req_valid <= 1'b0;
      while (sb.pending_writes.size() != 0)
         @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(int rows, int send_idle, int stall);
      send_idle_pct = send_idle;
      rsp_stall_pct <= stall;
      repeat (rows) send_row(random_row());
      drain_writes();
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 32 bpp with a base just below the top so the first row wraps
      apply_settings(1'b1, 32'hFFFF_FFF0, 13'd64, 13'd32, 15'd256, grpw_pkg::FMT_32BPP);
      send_glyph_row(0, 0, 0, 8'hFF, 32'h1234_5678, grpw_pkg::TRANSPARENT_COLOR);
      send_glyph_row(0, 0, 1, 8'h00, 32'h1234_5678, 32'hFFFF_FFFE);
      // all clear and transparent: nothing drawn
      send_glyph_row(0, 0, 2, 8'h00, 32'h1234_5678, grpw_pkg::TRANSPARENT_COLOR);
      send_glyph_row(10, 5, 15, 8'hA5, 32'hFFFF_FFFF, 32'h0000_0000);
      // left and right clipping
      send_glyph_row(-3, 2, 0, 8'hFF, 32'hCAFE_F00D, 32'h0F0F_0F0F);
      send_glyph_row(60, 2, 3, 8'hF0, 32'h5555_AAAA, 32'hAAAA_5555);
      // position extremes, both fully off screen
      send_glyph_row(-32768, -32768, 0, 8'hFF, 32'h0000_0001, 32'h8000_0000);
      send_glyph_row(32767, 32767, 15, 8'hFF, 32'h0000_0001, 32'h8000_0000);
      // negative glyph top whose last row hits line zero
      send_glyph_row(5, -15, 15, 8'h5A, 32'h0102_0304, 32'h0506_0708);
      // bottom line and one past it
      send_glyph_row(5, 16, 15, 8'hC3, 32'h0102_0304, 32'h0506_0708);
      send_glyph_row(5, 17, 15, 8'hFF, 32'h0102_0304, 32'h0506_0708);
      send_glyph_row(56, -1, 0, 8'h81, 32'h0102_0304, 32'h0506_0708);
      send_glyph_row(56, 0, 7, 8'h7E, 32'h0000_0000, 32'h8000_0001);
      drain_writes();

      // directed: 16 bpp masks the color to two bytes
      apply_settings(1'b1, 32'h0000_0100, 13'd64, 13'd32, 15'd128, grpw_pkg::FMT_16BPP);
      send_glyph_row(0, 4, 0, 8'hAA, 32'hDEAD_BEEF, 32'h1234_5678);
      send_glyph_row(62, 4, 1, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_glyph_row(1, 1, 2, 8'h55, 32'h8765_4321, grpw_pkg::TRANSPARENT_COLOR);
      drain_writes();

      // directed: 24 bpp masks to three bytes
      apply_settings(1'b1, 32'h8000_0000, 13'd64, 13'd32, 15'd192, grpw_pkg::FMT_24BPP);
      send_glyph_row(0, 0, 9, 8'hAA, 32'hDEAD_BEEF, 32'h1234_5678);
      send_glyph_row(-7, 3, 0, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_glyph_row(63, 31, 0, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
      drain_writes();

      // directed: unused format code draws nothing
      apply_settings(1'b1, 32'h0000_0000, 13'd64, 13'd32, 15'd256, FMT_UNUSED);
      send_glyph_row(0, 0, 0, 8'hFF, 32'h1111_1111, 32'h2222_2222);
      send_glyph_row(8, 8, 4, 8'h00, 32'h1111_1111, 32'h2222_2222);
      drain_writes();

      // directed: drawing disabled
      apply_settings(1'b0, 32'h0000_0000, 13'd64, 13'd32, 15'd256, grpw_pkg::FMT_32BPP);
      send_glyph_row(0, 0, 0, 8'hFF, 32'h1111_1111, 32'h2222_2222);
      send_glyph_row(8, 8, 4, 8'h00, 32'h1111_1111, 32'h2222_2222);
      drain_writes();

      // random: small screen, pitch of one, no idling
      apply_settings(1'b1, $urandom(), 13'd64, 13'd48, 15'd1, grpw_pkg::FMT_16BPP);
      random_phase(70, 0, 0);

      // random: largest nominal screen, base at the top, sender idles
      apply_settings(1'b1, 32'hFFFF_FFFF, 13'd4096, 13'd4096, 15'd16384, grpw_pkg::FMT_32BPP);
      random_phase(70, 67, 0);

      // random: single-pixel screen, receiver stalls
      apply_settings(1'b1, 32'h0000_0000, 13'd1, 13'd1, 15'd16384, grpw_pkg::FMT_24BPP);
      random_phase(50, 0, 67);

      // random: screen and pitch fields at their top values, both sides idle
      apply_settings(1'b1, $urandom(), 13'h1FFF, 13'h1FFF, 15'h7FFF, grpw_pkg::FMT_32BPP);
      random_phase(70, 25, 25);

      // back pressure: responses held off for a long stretch while requests keep
      // coming, so the block fills up and must stall its request side
      apply_settings(1'b1, $urandom(), 13'd1024, 13'd768, 15'd4096, grpw_pkg::FMT_16BPP);
      hold_requests <= hold_requests + 1;
      random_phase(60, 0, 0);

      // zero width, then zero height: everything clipped
      apply_settings(1'b1, $urandom(), 13'd0, 13'd100, 15'd400, grpw_pkg::FMT_24BPP);
      random_phase(15, 25, 25);
      apply_settings(1'b1, $urandom(), 13'd100, 13'd0, 15'd400, grpw_pkg::FMT_32BPP);
      random_phase(10, 25, 25);

      // unused format, then disabled
      apply_settings(1'b1, $urandom(), 13'd256, 13'd256, 15'd1024, FMT_UNUSED);
      random_phase(15, 67, 0);
      apply_settings(1'b0, $urandom(), 13'd256, 13'd256, 15'd1024, grpw_pkg::FMT_32BPP);
      random_phase(15, 0, 67);

      // a typical mode to finish, both sides idle
      apply_settings(1'b1, $urandom(), 13'd640, 13'd480, 15'd1920, grpw_pkg::FMT_24BPP);
      random_phase(60, 25, 25);

      $display("run covered %0d row requests, %0d pixel writes, %0d register writes, %0d settings",
               sb.rows_noted, sb.writes_checked, sb.registers_written, settings_applied);
      $display("incl. all pixel formats, clipping on every edge, transparency, wrap and hold-off");
      if (sb.mismatches == 0 && sb.pending_writes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/grpw_pkg.sv
hw/rtl/glyph_row_pixel_writer_top.sv
tb/tb_glyph_row_pixel_writer_top.sv
